// ----- sv/wes_pkg.sv -----
// Shared widths, codes and constants for the wheel encoder speed estimator.
package wes_pkg;

  // Field and state widths.
  localparam int PHASE_W   = 10;
  localparam int REQ_W     = 2;
  localparam int SPEED_W   = 24;
  localparam int COUNT_W   = 32;
  localparam int DIST_W    = 48;
  localparam int DPN_W     = 12;
  localparam int PAUSE_W   = 11;
  localparam int ELAPSED_W = 21;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 12;

  // Serial divider widths: the dividend is dist_per_notch * 1e6 (below 2^32),
  // the divisor is a positive notch period in microseconds (below 2^22).
  localparam int SCALE_W   = 20;
  localparam int DIVIDEND_W = 32;
  localparam int DIVISOR_W = 22;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_EDGE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIST_PER_NOTCH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAUSE_LIMIT = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [DPN_W-1:0]   DPN_RESET   = 12'd282;
  localparam logic [PAUSE_W-1:0] PAUSE_RESET = 11'd1000;

  // Arithmetic constants.
  localparam logic [SCALE_W-1:0] US_PER_S   = 20'd1000000;
  localparam logic [SPEED_W-1:0] SPEED_MAX  = 24'hFFFFFF;
  // Below 0.1 cm/s in 1/256 cm/s units.
  localparam logic [SPEED_W-1:0] SLOW_LIMIT = 24'd26;

endpackage

// ----- sv/wheel_encoder_speed_estimator_core.sv -----
// Top level of the wheel encoder speed estimator (one wheel channel).
//
// Usage: each input item (in_valid/in_ready) is a notch edge with its timer
// phase, a millisecond tick, or a request to clear the notch count. Every
// item yields exactly one result item (out_valid/out_ready) carrying the
// smoothed speed, the notch count and the distance after the item applied.
// Configuration is written through cfg_we/cfg_index/cfg_data with no wait.
// Ticks, clears, unused requests, edges with a saturating period and the
// first edge after a pause go from idle straight to the post state.
// An edge that closes a notch period runs the 32-step serial divider, one
// quotient bit per step, and then moves to the post state. The post state
// loads the output register and raises out_valid once it is free. Items are
// handled one at a time; in_ready is high whenever no item is in progress,
// also while a result waits. Reset clears speed, notch count and period state
// and loads the register defaults. When the receiver stalls, the result
// waits in the output register and the next item's result is held until the
// register frees.
module wheel_encoder_speed_estimator_core #(
  parameter int TICK_US = 1000
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [wes_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wes_pkg::CFG_DAT_W-1:0]      cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [wes_pkg::REQ_W-1:0]          req_type,
  input  logic [wes_pkg::PHASE_W-1:0]        tick_phase,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [wes_pkg::SPEED_W-1:0]        speed,
  output logic [wes_pkg::COUNT_W-1:0]        notch_count,
  output logic [wes_pkg::DIST_W-1:0]         distance
);

  localparam int TickW = $clog2(TICK_US + 1);
  localparam int ThrW  = wes_pkg::PAUSE_W + 1 + TickW;
  localparam int CmpW  = (ThrW > wes_pkg::ELAPSED_W) ? ThrW : wes_pkg::ELAPSED_W;
  localparam int PerW  = wes_pkg::DIVISOR_W + 1;
  localparam logic [TickW-1:0] TickC = TickW'(TICK_US);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_POST = 2'd2;

  // Configuration registers.
  logic                          count_enable;
  logic [wes_pkg::DPN_W-1:0]     dist_per_notch;
  logic [wes_pkg::PAUSE_W-1:0]   pause_limit_ms;

  // Channel state.
  logic [wes_pkg::ELAPSED_W-1:0] elapsed_us, elapsed_us_next;
  logic [wes_pkg::PHASE_W-1:0]   last_phase, last_phase_next;
  logic [wes_pkg::SPEED_W-1:0]   speed_reg, speed_reg_next;
  logic [wes_pkg::COUNT_W-1:0]   notch_total, notch_total_next;
  logic [1:0]                    state, state_next;

  logic                          accept;
  logic signed [PerW-1:0]        period;
  logic                          period_bad;
  logic                          div_start;
  logic                          div_done;
  logic [wes_pkg::DIVIDEND_W-1:0] dividend;
  logic [wes_pkg::DIVIDEND_W-1:0] quotient;
  logic [wes_pkg::SPEED_W-1:0]   raw_div;
  logic [wes_pkg::ELAPSED_W-1:0] elapsed_tick;
  logic [ThrW-1:0]               pause_thr;
  logic                          out_free;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_enable   <= 1'b0;
      dist_per_notch <= wes_pkg::DPN_RESET;
      pause_limit_ms <= wes_pkg::PAUSE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        wes_pkg::REG_COUNT_ENABLE:   count_enable   <= cfg_data[0];
        wes_pkg::REG_DIST_PER_NOTCH: dist_per_notch <= cfg_data[wes_pkg::DPN_W-1:0];
        wes_pkg::REG_PAUSE_LIMIT:    pause_limit_ms <= cfg_data[wes_pkg::PAUSE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;

  // Notch period since the last edge; zero or negative saturates the raw speed.
  assign period = $signed({2'b00, elapsed_us})
                + $signed({{(PerW-wes_pkg::PHASE_W){1'b0}}, tick_phase})
                - $signed({{(PerW-wes_pkg::PHASE_W){1'b0}}, last_phase}) - PerW'(1);
  assign period_bad = period[PerW-1] | (period == '0);

  // Divider input: distance per notch scaled to per second.
  assign dividend = wes_pkg::DIVIDEND_W'(dist_per_notch)
                  * wes_pkg::DIVIDEND_W'(wes_pkg::US_PER_S);

  // Saturate the quotient to the speed width.
  assign raw_div = (|quotient[wes_pkg::DIVIDEND_W-1:wes_pkg::SPEED_W]) ? wes_pkg::SPEED_MAX
                                                                       : quotient[wes_pkg::SPEED_W-1:0];

  // Tick: extend a running period, then test it against the pause limit.
  assign elapsed_tick = (elapsed_us != '0) ? elapsed_us + wes_pkg::ELAPSED_W'(TickC) : elapsed_us;
  assign pause_thr    = (ThrW'(pause_limit_ms) + ThrW'(1)) * ThrW'(TickC);

  wes_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (period[wes_pkg::DIVISOR_W-1:0]),
    .done     (div_done),
    .quotient (quotient)
  );

  // Blend a raw speed into the stored one, or take it outright below the slow limit.
  function automatic logic [wes_pkg::SPEED_W-1:0] smooth(
    input logic [wes_pkg::SPEED_W-1:0] raw,
    input logic [wes_pkg::SPEED_W-1:0] cur
  );
    logic [wes_pkg::SPEED_W:0] sum;
    sum = {1'b0, raw} + {1'b0, cur};
    if (cur < wes_pkg::SLOW_LIMIT) begin
      return raw;
    end
    return sum[wes_pkg::SPEED_W:1];
  endfunction

  // Request handling and sequencing.
  always_comb begin
    state_next       = state;
    elapsed_us_next  = elapsed_us;
    last_phase_next  = last_phase;
    speed_reg_next   = speed_reg;
    notch_total_next = notch_total;
    div_start        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_POST;
          case (req_type)
            wes_pkg::REQ_EDGE: begin
              if (count_enable) begin
                notch_total_next = notch_total + wes_pkg::COUNT_W'(1);
              end
              last_phase_next = tick_phase;
              if (elapsed_us == '0) begin
                elapsed_us_next = wes_pkg::ELAPSED_W'(tick_phase) + wes_pkg::ELAPSED_W'(1);
              end else begin
                elapsed_us_next = wes_pkg::ELAPSED_W'(1);
                if (period_bad) begin
                  speed_reg_next = smooth(wes_pkg::SPEED_MAX, speed_reg);
                end else begin
                  div_start  = 1'b1;
                  state_next = ST_DIV;
                end
              end
            end
            wes_pkg::REQ_TICK: begin
              elapsed_us_next = elapsed_tick;
              if (CmpW'(elapsed_tick) >= CmpW'(pause_thr)) begin
                speed_reg_next  = '0;
                elapsed_us_next = '0;
              end
            end
            wes_pkg::REQ_CLEAR: begin
              notch_total_next = '0;
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (div_done) begin
          speed_reg_next = smooth(raw_div, speed_reg);
          state_next     = ST_POST;
        end
      end
      ST_POST: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      elapsed_us  <= '0;
      last_phase  <= '0;
      speed_reg   <= '0;
      notch_total <= '0;
    end else begin
      state       <= state_next;
      elapsed_us  <= elapsed_us_next;
      last_phase  <= last_phase_next;
      speed_reg   <= speed_reg_next;
      notch_total <= notch_total_next;
    end
  end

  // Output register: loaded from the updated state once it is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_POST && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_POST && out_free) begin
      speed       <= speed_reg;
      notch_count <= notch_total;
      distance    <= wes_pkg::DIST_W'(notch_total * dist_per_notch);
    end
  end

`ifndef ASSERT_OFF
  // Every accepted item leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != ST_IDLE)
    else $error("accepted item did not start processing");

  // The divider only finishes while the sequencer waits for it.
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide state");

  // A new result only appears after the post state loaded it.
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_POST)
    else $error("result shown without a load");

  // The notch count does not move during a division.
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |=> $stable(notch_total))
    else $error("notch count changed during division");
`endif

endmodule

// ----- sv/wes_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
module wes_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [wes_pkg::DIVIDEND_W-1:0]      dividend,
  input  logic [wes_pkg::DIVISOR_W-1:0]       divisor,
  output logic                                done,
  output logic [wes_pkg::DIVIDEND_W-1:0]      quotient
);

  localparam int CntW = $clog2(wes_pkg::DIVIDEND_W);
  localparam logic [CntW-1:0] CntLast = CntW'(wes_pkg::DIVIDEND_W - 1);

  logic                             busy;
  logic [CntW-1:0]                  cnt;
  logic [wes_pkg::DIVIDEND_W-1:0]   quo;
  logic [wes_pkg::DIVISOR_W-1:0]    rem;
  logic [wes_pkg::DIVISOR_W-1:0]    dvs;
  logic [wes_pkg::DIVISOR_W:0]      rem_sh;
  logic [wes_pkg::DIVISOR_W+1:0]    diff;
  logic                             qbit;
  logic [wes_pkg::DIVISOR_W-1:0]    rem_next;

  // One restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    rem_sh   = {rem, quo[wes_pkg::DIVIDEND_W-1]};
    diff     = {1'b0, rem_sh} - {2'b00, dvs};
    qbit     = ~diff[wes_pkg::DIVISOR_W+1];
    rem_next = qbit ? diff[wes_pkg::DIVISOR_W-1:0] : rem_sh[wes_pkg::DIVISOR_W-1:0];
  end

  // Control: a counter over the dividend bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CntW'(1);
        if (cnt == CntLast) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: the quotient shifts in where the dividend shifts out.
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[wes_pkg::DIVIDEND_W-2:0], qbit};
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

// ----- bench/testbench.sv -----
// Self-checking testbench for the wheel encoder speed estimator core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Request code that the block does not use; such an item only reports the state.
  localparam logic [wes_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam int TICK_US         = 1000;
  localparam int TAIL_CYCLES     = 50;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RANDOM_PHASES   = 14;
  localparam int ITEMS_PER_PHASE = 95;
  localparam int PHASE_MAX       = 999;

  // One result item as the block reports it.
  typedef struct packed {
    logic [wes_pkg::SPEED_W-1:0] speed;
    logic [wes_pkg::COUNT_W-1:0] count;
    logic [wes_pkg::DIST_W-1:0]  travel;
  } wheel_reading_t;

  // Tracks the wheel state, predicts each reading and checks the block against it.
  class wheel_speed_scoreboard;
    logic                          cnt_en;
    logic [wes_pkg::DPN_W-1:0]     dpn;
    logic [wes_pkg::PAUSE_W-1:0]   pause_ms;
    logic [wes_pkg::ELAPSED_W-1:0] elapsed;
    logic [wes_pkg::PHASE_W-1:0]   last_phase;
    logic [wes_pkg::SPEED_W-1:0]   speed_acc;
    logic [wes_pkg::COUNT_W-1:0]   notches;
    wheel_reading_t                expected_readings[$];
    int                            error_count;

    function new();
      cnt_en      = 1'b0;
      dpn         = wes_pkg::DPN_RESET;
      pause_ms    = wes_pkg::PAUSE_RESET;
      elapsed     = '0;
      last_phase  = '0;
      speed_acc   = '0;
      notches     = '0;
      error_count = 0;
    endfunction

    // Register writes keep only the bits that fit the register.
    function void set_reg(logic [wes_pkg::CFG_IDX_W-1:0] idx,
                          logic [wes_pkg::CFG_DAT_W-1:0] data);
      case (idx)
        wes_pkg::REG_COUNT_ENABLE:   cnt_en = data[0];
        wes_pkg::REG_DIST_PER_NOTCH: dpn = data[wes_pkg::DPN_W-1:0];
        wes_pkg::REG_PAUSE_LIMIT:    pause_ms = data[wes_pkg::PAUSE_W-1:0];
        default: ;
      endcase
    endfunction

    // Applies one accepted item to the wheel state and queues the reading it yields.
    function void note_item(logic [wes_pkg::REQ_W-1:0] req, logic [wes_pkg::PHASE_W-1:0] phase);
      longint                      period;
      longint                      quot;
      logic [wes_pkg::SPEED_W-1:0] raw;
      logic [wes_pkg::SPEED_W:0]   sum;
      logic [63:0]                 prod;
      wheel_reading_t              r;
      case (req)
        wes_pkg::REQ_EDGE: begin
          if (cnt_en) notches = notches + wes_pkg::COUNT_W'(1);
          if (elapsed == '0) begin
            // First edge after a pause only starts the period.
            last_phase = phase;
            elapsed = wes_pkg::ELAPSED_W'(phase) + wes_pkg::ELAPSED_W'(1);
          end else begin
            period = longint'(elapsed) + longint'(phase) - longint'(last_phase) - 1;
            // A period that is zero or negative saturates the raw speed.
            if (period <= 0) begin
              raw = wes_pkg::SPEED_MAX;
            end else begin
              quot = (longint'(dpn) * 64'sd1000000) / period;
              raw = (quot > longint'(wes_pkg::SPEED_MAX)) ? wes_pkg::SPEED_MAX
                                                           : quot[wes_pkg::SPEED_W-1:0];
            end
            // Slow speeds are replaced outright, faster ones averaged.
            if (speed_acc < wes_pkg::SLOW_LIMIT) begin
              speed_acc = raw;
            end else begin
              sum = {1'b0, raw} + {1'b0, speed_acc};
              speed_acc = sum[wes_pkg::SPEED_W:1];
            end
            last_phase = phase;
            elapsed = wes_pkg::ELAPSED_W'(1);
          end
        end
        wes_pkg::REQ_TICK: begin
          if (elapsed != '0) elapsed = elapsed + wes_pkg::ELAPSED_W'(TICK_US);
          if (elapsed / TICK_US > pause_ms) begin
            speed_acc = '0;
            elapsed = '0;
          end
        end
        wes_pkg::REQ_CLEAR: notches = '0;
        default: ;
      endcase
      prod = 64'(notches) * 64'(dpn);
      r.speed = speed_acc;
      r.count = notches;
      r.travel = prod[wes_pkg::DIST_W-1:0];
      expected_readings.push_back(r);
    endfunction

    // Compares one accepted reading with the oldest prediction.
    function void check_result(logic [wes_pkg::SPEED_W-1:0] spd,
                               logic [wes_pkg::COUNT_W-1:0] cnt,
                               logic [wes_pkg::DIST_W-1:0] travel);
      wheel_reading_t r;
      if (expected_readings.size() == 0) begin
        $display("%0t: reading with none expected: speed %0d count %0d distance %0d",
                 $time, spd, cnt, travel);
        error_count++;
        return;
      end
      r = expected_readings.pop_front();
      if (spd !== r.speed) begin
        $display("%0t: speed mismatch, expected %0d, actual %0d", $time, r.speed, spd);
        error_count++;
      end
      if (cnt !== r.count) begin
        $display("%0t: notch_count mismatch, expected %0d, actual %0d", $time, r.count, cnt);
        error_count++;
      end
      if (travel !== r.travel) begin
        $display("%0t: distance mismatch, expected %0d, actual %0d", $time, r.travel, travel);
        error_count++;
      end
    endfunction

    function int pending();
      return expected_readings.size();
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [wes_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [wes_pkg::CFG_DAT_W-1:0] cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  logic [wes_pkg::REQ_W-1:0]     req_type;
  logic [wes_pkg::PHASE_W-1:0]   tick_phase;
  logic                          out_valid;
  logic                          out_ready;
  logic [wes_pkg::SPEED_W-1:0]   speed;
  logic [wes_pkg::COUNT_W-1:0]   notch_count;
  logic [wes_pkg::DIST_W-1:0]    distance;

  wheel_speed_scoreboard sb = new();
  int unsigned max_gap;
  int unsigned max_stall;
  int          idle_cycles;

  wheel_encoder_speed_estimator_core #(
    .TICK_US(TICK_US)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .req_type(req_type),
    .tick_phase(tick_phase),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .speed(speed),
    .notch_count(notch_count),
    .distance(distance)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check every reading the block hands over.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(speed, notch_count, distance);
  end

  // Stop the run when no handshake or write happens for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("** wheel_encoder_speed_estimator_core: FAILED **");
      $finish;
    end
  end

  // Receiver: stall a random number of cycles before taking each reading.
  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      stall = $urandom_range(0, max_stall);
      @(negedge clk);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Offer one item after a random gap and hold it until the block takes it.
  task automatic send_item(input logic [wes_pkg::REQ_W-1:0] req,
                           input logic [wes_pkg::PHASE_W-1:0] phase);
    int unsigned gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    req_type <= req;
    tick_phase <= phase;
    do @(posedge clk); while (!in_ready);
    sb.note_item(req, phase);
  endtask

  // Stop sending and wait until every reading is back and the block is quiet.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [wes_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wes_pkg::CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [wes_pkg::PHASE_W-1:0] any_phase();
    return wes_pkg::PHASE_W'($urandom_range(0, PHASE_MAX));
  endfunction

  // Mostly plausible encoder traffic: edges move forward within a tick, ticks
  // restart the timer, with clears, unused requests and stray edges mixed in.
  task automatic run_wheel_traffic(input int n);
    int unsigned draw;
    int          cur;
    int          ph;
    int          i;
    cur = 0;
    for (i = 0; i < n; i++) begin
      draw = $urandom_range(0, 99);
      if (draw < 45) begin
        ph = cur + int'($urandom_range(0, 300));
        if (ph > PHASE_MAX) ph = PHASE_MAX;
        cur = ph;
        send_item(wes_pkg::REQ_EDGE, wes_pkg::PHASE_W'(ph));
      end else if (draw < 78) begin
        cur = 0;
        send_item(wes_pkg::REQ_TICK, any_phase());
      end else if (draw < 85) begin
        // A run of ticks can let the pause limit expire.
        cur = 0;
        repeat ($urandom_range(2, 8)) send_item(wes_pkg::REQ_TICK, any_phase());
      end else if (draw < 90) begin
        send_item(wes_pkg::REQ_CLEAR, any_phase());
      end else if (draw < 93) begin
        send_item(REQ_UNUSED, any_phase());
      end else begin
        ph = int'(any_phase());
        cur = ph;
        send_item(wes_pkg::REQ_EDGE, wes_pkg::PHASE_W'(ph));
      end
    end
  endtask

  initial begin
    int p;
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = wes_pkg::REQ_EDGE;
    tick_phase = '0;
    cfg_we = 1'b0;
    cfg_index = wes_pkg::REG_COUNT_ENABLE;
    cfg_data = '0;
    max_gap = 15;
    max_stall = 15;
    idle_cycles = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: a tick with no edge pending, a first edge, an unused
    // request and a measured period with counting disabled.
    send_item(wes_pkg::REQ_TICK, 10'd0);
    send_item(wes_pkg::REQ_EDGE, 10'd0);
    send_item(REQ_UNUSED, 10'd999);
    send_item(wes_pkg::REQ_EDGE, 10'd999);
    drain();

    // Widest notch distance and a short pause limit.
    write_reg(wes_pkg::REG_COUNT_ENABLE, 12'd1);
    write_reg(wes_pkg::REG_DIST_PER_NOTCH, 12'd4095);
    write_reg(wes_pkg::REG_PAUSE_LIMIT, 12'd2);
    send_item(wes_pkg::REQ_EDGE, 10'd10);    // phase went backwards: saturates
    send_item(wes_pkg::REQ_EDGE, 10'd10);    // phase did not move: saturates
    send_item(wes_pkg::REQ_TICK, 10'd0);
    send_item(wes_pkg::REQ_EDGE, 10'd500);
    repeat (3) send_item(wes_pkg::REQ_TICK, 10'd0);  // pause limit runs out
    send_item(wes_pkg::REQ_EDGE, 10'd999);
    send_item(wes_pkg::REQ_TICK, 10'd0);
    send_item(wes_pkg::REQ_EDGE, 10'd0);
    send_item(wes_pkg::REQ_CLEAR, 10'd0);
    send_item(wes_pkg::REQ_EDGE, 10'd998);
    drain();

    // Oversized writes are masked: enable stays set, pause limit becomes its maximum.
    write_reg(wes_pkg::REG_COUNT_ENABLE, 12'hFFF);
    write_reg(wes_pkg::REG_DIST_PER_NOTCH, 12'd1);
    write_reg(wes_pkg::REG_PAUSE_LIMIT, 12'hFFF);
    send_item(wes_pkg::REQ_EDGE, 10'd0);
    send_item(wes_pkg::REQ_EDGE, 10'd1);
    // A run of ticks without gaps that stays within the longest pause limit.
    max_gap = 0;
    repeat (20) send_item(wes_pkg::REQ_TICK, any_phase());
    max_gap = 15;
    drain();

    // Zero distance per notch, and an enable write whose low bit is clear.
    write_reg(wes_pkg::REG_COUNT_ENABLE, 12'hFFE);
    write_reg(wes_pkg::REG_DIST_PER_NOTCH, 12'd0);
    send_item(wes_pkg::REQ_EDGE, 10'd5);
    send_item(wes_pkg::REQ_TICK, 10'd0);
    send_item(wes_pkg::REQ_EDGE, 10'd7);
    send_item(wes_pkg::REQ_EDGE, 10'd7);
    drain();

    // Random traffic under a new random setting per phase.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      write_reg(wes_pkg::REG_COUNT_ENABLE, wes_pkg::CFG_DAT_W'($urandom_range(0, 1)));
      case ($urandom_range(0, 5))
        0:       write_reg(wes_pkg::REG_DIST_PER_NOTCH, 12'd0);
        1:       write_reg(wes_pkg::REG_DIST_PER_NOTCH, 12'd1);
        2:       write_reg(wes_pkg::REG_DIST_PER_NOTCH, 12'd4095);
        default: write_reg(wes_pkg::REG_DIST_PER_NOTCH,
                           wes_pkg::CFG_DAT_W'($urandom_range(1, 4095)));
      endcase
      case ($urandom_range(0, 4))
        0:       write_reg(wes_pkg::REG_PAUSE_LIMIT, 12'd1);
        1:       write_reg(wes_pkg::REG_PAUSE_LIMIT, 12'd2000);
        default: write_reg(wes_pkg::REG_PAUSE_LIMIT, wes_pkg::CFG_DAT_W'($urandom_range(1, 6)));
      endcase
      max_gap = (p % 3 == 0) ? 0 : 15;
      max_stall = (p % 4 == 1) ? 0 : 15;
      run_wheel_traffic(ITEMS_PER_PHASE);
      drain();
    end

    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("** wheel_encoder_speed_estimator_core: PASSED **");
    end else begin
      $display("** wheel_encoder_speed_estimator_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/wes_pkg.sv
sv/wes_div.sv
sv/wheel_encoder_speed_estimator_core.sv
bench/testbench.sv
